// ===== hw/rtl/camera_ray_direction_gen_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ray direction generator checker
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CAMERA_RAY_DIRECTION_GEN_MACROS_SVH
`define CAMERA_RAY_DIRECTION_GEN_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CRDG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define CRDG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/crdg_pkg.sv =====
// ----------------------------------------------------------------------------
// crdg_pkg
// Shared constants, types and helper functions of the ray direction generator.
// ----------------------------------------------------------------------------
package crdg_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int MAX_RESOLUTION = 4096;
    localparam int FIFO_DEPTH_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TAN    = 3'd2;
    localparam logic [2:0] REG_NX     = 3'd3;
    localparam logic [2:0] REG_NY     = 3'd4;
    localparam logic [2:0] REG_NZ     = 3'd5;

    localparam logic signed [18:0] ONE_Q  = 19'sd65536;
    localparam logic signed [23:0] SAT_HI = 24'sh7FFFFF;
    localparam logic signed [23:0] SAT_LO = -24'sh800000;

    // camera-space point handed from front to back
    typedef struct packed {
        logic signed [23:0] cx;
        logic signed [23:0] cy;
    } cam_item_t;

    // subsample x offset in half pixels
    function automatic logic [1:0] sub_mod3(input logic [3:0] s);
        logic [1:0] r;
        case (s)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
            4'd2, 4'd5, 4'd8, 4'd11, 4'd14:       r = 2'd2;
            default:                              r = 2'd0;
        endcase
        return r;
    endfunction

    // subsample y offset in half pixels
    function automatic logic [2:0] sub_div3(input logic [3:0] s);
        logic [2:0] r;
        case (s)
            4'd0, 4'd1, 4'd2:    r = 3'd0;
            4'd3, 4'd4, 4'd5:    r = 3'd1;
            4'd6, 4'd7, 4'd8:    r = 3'd2;
            4'd9, 4'd10, 4'd11:  r = 3'd3;
            4'd12, 4'd13, 4'd14: r = 3'd4;
            4'd15:               r = 3'd5;
            default:             r = 3'd0;
        endcase
        return r;
    endfunction

    // divide by 2^FRAC_BITS, round to nearest, ties away from zero
    function automatic logic signed [47:0] shr_round48(input logic signed [47:0] v);
        logic        neg;
        logic [47:0] mag;
        logic [47:0] q;
        neg = v[47];
        mag = neg ? 48'(-v) : 48'(v);
        q   = (mag + (48'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return neg ? -$signed(q) : $signed(q);
    endfunction

    // clip to 24-bit signed
    function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
        logic signed [23:0] r;
        if (v > 48'(SAT_HI))      r = SAT_HI;
        else if (v < 48'(SAT_LO)) r = SAT_LO;
        else                      r = v[23:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/crdg_front.sv =====
// ----------------------------------------------------------------------------
// crdg_front
// Maps pixel and subsample to the camera-space point: multiply by the tangent
// and a pipelined restoring divide by the image height, four bits per stage.
// ----------------------------------------------------------------------------
module crdg_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [11:0]                in_col,
    input  logic [11:0]                in_row,
    input  logic [3:0]                 in_sub,
    input  logic [12:0]                w_c,
    input  logic [12:0]                h_c,
    input  logic [23:0]                tan_q,
    output logic                       out_valid,
    output crdg_pkg::cam_item_t        out_item
);
    import crdg_pkg::*;

    localparam int NUM_W      = 40;
    localparam int STEPS      = 4;
    localparam int DIV_STAGES = NUM_W / STEPS;

    // one divider lane: numerator shifts out while quotient bits shift in
    typedef struct packed {
        logic             neg;
        logic [NUM_W-1:0] nq;
        logic [12:0]      rem;
    } div_lane_t;

    typedef struct packed {
        div_lane_t lx;
        div_lane_t ly;
    } div_pair_t;

    function automatic div_lane_t div_steps(input div_lane_t l, input logic [12:0] d);
        div_lane_t   r;
        logic [13:0] t;
        r = l;
        for (int k = 0; k < STEPS; k++)
        begin
            t = {r.rem, r.nq[NUM_W-1]};
            if (t >= {1'b0, d})
            begin
                t    = t - {1'b0, d};
                r.nq = {r.nq[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r.nq = {r.nq[NUM_W-2:0], 1'b0};
            end
            r.rem = t[12:0];
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat_q(input div_lane_t l);
        logic signed [23:0] r;
        if (l.neg)
            r = (l.nq > NUM_W'(24'h800000)) ? SAT_LO : -$signed(l.nq[23:0]);
        else
            r = (l.nq > NUM_W'(24'h7FFFFF)) ? SAT_HI : $signed(l.nq[23:0]);
        return r;
    endfunction

    logic               a_valid_reg, b_valid_reg, c_valid_reg;
    logic               ax_neg_reg, ay_neg_reg;
    logic [14:0]        ax_mag_reg, ay_mag_reg;
    logic               bx_neg_reg, by_neg_reg;
    logic [38:0]        px_reg, py_reg;
    div_pair_t          c_reg;
    logic signed [15:0] ax_next, ay_next;
    logic [38:0]        px_next, py_next;
    div_pair_t          c_next;

    logic [DIV_STAGES-1:0] dv_reg;
    div_pair_t             dp_reg [DIV_STAGES];
    div_pair_t             dp_in  [DIV_STAGES];

    // stage A: signed offsets from the image center, split into sign and size
    always_comb
    begin
        ax_next = $signed({3'b0, w_c}) - $signed({3'b0, in_col, 1'b0})
                  - $signed({14'b0, sub_mod3(in_sub)});
        ay_next = $signed({3'b0, h_c}) - $signed({3'b0, in_row, 1'b0})
                  - $signed({13'b0, sub_div3(in_sub)});
    end

    // stage B: multiply by the tangent
    assign px_next = ax_mag_reg * tan_q;
    assign py_next = ay_mag_reg * tan_q;

    // stage C: add half the divisor for rounding
    always_comb
    begin
        c_next.lx.neg = bx_neg_reg;
        c_next.lx.nq  = {1'b0, px_reg} + NUM_W'(h_c >> 1);
        c_next.lx.rem = '0;
        c_next.ly.neg = by_neg_reg;
        c_next.ly.nq  = {1'b0, py_reg} + NUM_W'(h_c >> 1);
        c_next.ly.rem = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_neg_reg <= ax_next[15];
        ay_neg_reg <= ay_next[15];
        ax_mag_reg <= ax_next[15] ? 15'(-ax_next) : ax_next[14:0];
        ay_mag_reg <= ay_next[15] ? 15'(-ay_next) : ay_next[14:0];
        bx_neg_reg <= ax_neg_reg;
        by_neg_reg <= ay_neg_reg;
        px_reg     <= px_next;
        py_reg     <= py_next;
        c_reg      <= c_next;
    end

    // divider stages
    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++)
        begin : g_div
            if (g == 0)
            begin : g_first
                assign dp_in[g] = c_reg;
            end
            else
            begin : g_rest
                assign dp_in[g] = dp_reg[g-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_reg[g] <= 1'b0;
                else if (g == 0)
                    dv_reg[g] <= c_valid_reg;
                else
                    dv_reg[g] <= dv_reg[(g == 0) ? 0 : g-1];
            end

            always_ff @(posedge clk)
            begin
                dp_reg[g].lx <= div_steps(dp_in[g].lx, h_c);
                dp_reg[g].ly <= div_steps(dp_in[g].ly, h_c);
            end
        end
    endgenerate

    // apply sign and saturate on the way into the queue
    assign out_valid   = dv_reg[DIV_STAGES-1];
    assign out_item.cx = sat_q(dp_reg[DIV_STAGES-1].lx);
    assign out_item.cy = sat_q(dp_reg[DIV_STAGES-1].ly);

endmodule

// ===== hw/rtl/crdg_queue.sv =====
// ----------------------------------------------------------------------------
// crdg_queue
// Small FIFO of camera points between the front and back parts, with a
// registered head so the storage is both written and read on the clock.
// ----------------------------------------------------------------------------
module crdg_queue #(
    parameter int DEPTH = crdg_pkg::FIFO_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  crdg_pkg::cam_item_t wr_item,
    input  logic                rd_en,
    output crdg_pkg::cam_item_t rd_item,
    output logic                empty
);
    import crdg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cam_item_t       mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    cam_item_t       out_item_reg;
    logic            out_valid_reg;
    logic            head_free;
    logic            fetch;
    logic            bypass;
    logic            mem_wr;

    function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // head register is free this cycle, or is being taken
    assign head_free = !out_valid_reg || rd_en;
    // oldest stored item moves to the head
    assign fetch     = (count_reg != '0) && head_free;
    // item goes straight to the head when storage is empty and the head is free
    assign bypass    = wr_en && (count_reg == '0) && head_free;
    assign mem_wr    = wr_en && !bypass;

    // storage and head data
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[wr_ptr_reg] <= wr_item;
        if (fetch)
            out_item_reg <= mem[rd_ptr_reg];
        else if (bypass)
            out_item_reg <= wr_item;
    end

    assign rd_item = out_item_reg;
    assign empty   = !out_valid_reg;

    // pointers, fill count and head valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_wr)
                wr_ptr_reg <= inc_ptr(wr_ptr_reg);
            if (fetch)
                rd_ptr_reg <= inc_ptr(rd_ptr_reg);
            if (mem_wr && !fetch)
                count_reg <= count_reg + 1'b1;
            else if (fetch && !mem_wr)
                count_reg <= count_reg - 1'b1;
            if (fetch || bypass)
                out_valid_reg <= 1'b1;
            else if (rd_en)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== hw/rtl/crdg_back.sv =====
// ----------------------------------------------------------------------------
// crdg_back
// Builds the look-at basis from the view normal and rotates the camera point
// into world space; four stages with an elastic valid/ready chain.
// ----------------------------------------------------------------------------
module crdg_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_empty,
    input  crdg_pkg::cam_item_t        q_item,
    output logic                       q_pop,
    input  logic signed [18:0]         nx,
    input  logic signed [18:0]         ny,
    input  logic signed [18:0]         nz,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [71:0]                out_data
);
    import crdg_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic r1, r2, r3, r4;

    // stage 1
    logic signed [23:0] cx1_reg, cy1_reg;
    logic signed [19:0] bx0_1_reg, bx2_1_reg;
    logic signed [38:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [19:0] bx0_next, bx2_next;
    // stage 2
    logic signed [23:0] cx2_reg, cy2_reg;
    logic signed [19:0] bx0_2_reg, bx2_2_reg;
    logic signed [22:0] by0_reg, by1_reg, by2_reg;
    // stage 3
    logic signed [43:0] m0a_reg, m2a_reg;
    logic signed [46:0] m0b_reg, m1_reg, m2b_reg;
    // stage 4 sums
    logic signed [47:0] s0, s1, s2;
    logic signed [23:0] r0_reg, r1_reg, r2_reg;

    // elastic handshake
    assign r4    = !v4_reg || out_ready;
    assign r3    = !v3_reg || r4;
    assign r2    = !v2_reg || r3;
    assign r1    = !v1_reg || r2;
    assign q_pop = !q_empty && r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= q_pop;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
        end
    end

    // basis x, with the fixed axis when the normal points straight up or down
    always_comb
    begin
        if (ny == ONE_Q)
        begin
            bx0_next = 20'(ONE_Q);
            bx2_next = '0;
        end
        else if (ny == -ONE_Q)
        begin
            bx0_next = -20'(ONE_Q);
            bx2_next = '0;
        end
        else
        begin
            bx0_next = 20'(nz);
            bx2_next = -20'(nx);
        end
    end

    // stage 1: basis cross-product terms
    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            cx1_reg   <= q_item.cx;
            cy1_reg   <= q_item.cy;
            bx0_1_reg <= bx0_next;
            bx2_1_reg <= bx2_next;
            pa_reg    <= ny * bx2_next;
            pb_reg    <= nz * bx0_next;
            pc_reg    <= nx * bx2_next;
            pd_reg    <= ny * bx0_next;
        end
    end

    // stage 2: basis y rounded back to Q.16
    always_ff @(posedge clk)
    begin
        if (r2)
        begin
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            bx0_2_reg <= bx0_1_reg;
            bx2_2_reg <= bx2_1_reg;
            by0_reg   <= 23'(shr_round48(48'(pa_reg)));
            by1_reg   <= 23'(shr_round48(48'(pb_reg) - 48'(pc_reg)));
            by2_reg   <= 23'(shr_round48(-48'(pd_reg)));
        end
    end

    // stage 3: rotation products
    always_ff @(posedge clk)
    begin
        if (r3)
        begin
            m0a_reg <= cx2_reg * bx0_2_reg;
            m0b_reg <= cy2_reg * by0_reg;
            m1_reg  <= cy2_reg * by1_reg;
            m2a_reg <= cx2_reg * bx2_2_reg;
            m2b_reg <= cy2_reg * by2_reg;
        end
    end

    // stage 4: add the normal term, round and saturate
    always_comb
    begin
        s0 = 48'(m0a_reg) + 48'(m0b_reg) + (48'(nx) <<< FRAC_BITS);
        s1 = 48'(m1_reg) + (48'(ny) <<< FRAC_BITS);
        s2 = 48'(m2a_reg) + 48'(m2b_reg) + (48'(nz) <<< FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (r4)
        begin
            r0_reg <= sat24(shr_round48(s0));
            r1_reg <= sat24(shr_round48(s1));
            r2_reg <= sat24(shr_round48(s2));
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = {r2_reg, r1_reg, r0_reg};

endmodule

// ===== hw/rtl/camera_ray_direction_gen.sv =====
// ----------------------------------------------------------------------------
// camera_ray_direction_gen
// Pinhole camera primary ray direction generator.
// ----------------------------------------------------------------------------
// Takes one item per clock while s_tready is high and returns one
// world-space direction per item. An item passes through the front (offset,
// tangent multiply and a ten-stage divide by the image height), then the
// queue and the basis and rotation stages. Input is taken while the item
// count held between input and queue output stays below FIFO_DEPTH, so the
// queue can never overflow; with FIFO_DEPTH at least 15 the rate is one item
// per cycle as long as the output is taken. Configuration writes take effect
// at once and should be made with no items in flight.
module camera_ray_direction_gen #(
    parameter int FIFO_DEPTH = crdg_pkg::FIFO_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_col[11:0], pixel_row[23:12], subsample[27:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // dir_x[23:0], dir_y[47:24], dir_z[71:48]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_data
);
    import crdg_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [12:0]        width_reg, height_reg;
    logic [23:0]        tan_reg;
    logic signed [18:0] nx_reg, ny_reg, nz_reg;
    logic [12:0]        w_c, h_c;
    logic               accept;
    logic               f_valid;
    cam_item_t          f_item;
    cam_item_t          q_item;
    logic               q_empty, q_pop;
    logic [CW-1:0]      occ_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            tan_reg    <= 24'd65536;
            nx_reg     <= '0;
            ny_reg     <= '0;
            nz_reg     <= ONE_Q;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WIDTH:  width_reg  <= cfg_data[12:0];
                REG_HEIGHT: height_reg <= cfg_data[12:0];
                REG_TAN:    tan_reg    <= cfg_data;
                REG_NX:     nx_reg     <= cfg_data[18:0];
                REG_NY:     ny_reg     <= cfg_data[18:0];
                REG_NZ:     nz_reg     <= cfg_data[18:0];
                default:    ;
            endcase
        end
    end

    // clamp resolution; zero height counts as one
    assign w_c = (width_reg > 13'(MAX_RESOLUTION)) ? 13'(MAX_RESOLUTION) : width_reg;
    assign h_c = (height_reg > 13'(MAX_RESOLUTION)) ? 13'(MAX_RESOLUTION) :
                 (height_reg == '0) ? 13'd1 : height_reg;

    // credit count: items in the front and the queue
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (occ_reg < CW'(FIFO_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else if (accept && !q_pop)
            occ_reg <= occ_reg + 1'b1;
        else if (q_pop && !accept)
            occ_reg <= occ_reg - 1'b1;
    end

    crdg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_col    (s_tdata[11:0]),
        .in_row    (s_tdata[23:12]),
        .in_sub    (s_tdata[27:24]),
        .w_c       (w_c),
        .h_c       (h_c),
        .tan_q     (tan_reg),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    crdg_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid),
        .wr_item (f_item),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .empty   (q_empty)
    );

    crdg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .nx        (nx_reg),
        .ny        (ny_reg),
        .nz        (nz_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ===== hw/rtl/crdg_checker.sv =====
// ----------------------------------------------------------------------------
// crdg_checker
// Port-level checks of the ray direction generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "camera_ray_direction_gen_macros.svh"

module crdg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready
);
    logic acc;
    logic stall;

    assign acc   = s_tvalid && s_tready;
    assign stall = m_tvalid && !m_tready;

    // credits are only used up by accepted items
    `CRDG_ASSERT_IMP(a_ready_fall, $fell(s_tready), $past(acc), "ready fell without an item")
    // a fresh reset leaves every credit free
    `CRDG_ASSERT_IMP(a_ready_reset, !$past(rst_n), s_tready, "not ready after reset")
    // a stalled result stays offered
    `CRDG_ASSERT_NXT(a_out_hold, stall, m_tvalid, "result dropped under stall")

endmodule

bind camera_ray_direction_gen crdg_checker u_crdg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
